### sv/mrr_pkg.sv
// Package for the Modbus RTU response receiver: frame constants, status codes,
// result type, CRC-16 byte update and word-count decode. No dependencies.
`default_nettype none

package mrr_pkg;

	localparam int BUF_DEPTH_DEF = 256;
	localparam int HDR_LEN       = 11;
	localparam int HDR_IDX_W     = $clog2(HDR_LEN);
	localparam int MIN_FRAME     = 4;

	localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;

	localparam logic [7:0] FC_READ_COILS    = 8'h01;
	localparam logic [7:0] FC_READ_INPUTS   = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
	localparam logic [7:0] FC_READ_INPUT_RG = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
	localparam logic [7:0] FC_WRITE_REG     = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_GAP  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_ADDR  = 3'd2,
		ST_CRC   = 3'd3,
		ST_CODE  = 3'd4,
		ST_LEN   = 3'd5
	} status_t;

	typedef struct packed {
		logic [15:0] word_d;
		logic [15:0] word_c;
		logic [15:0] word_b;
		logic [15:0] word_a;
		logic [2:0]  word_count;
		logic [7:0]  function_code;
		status_t     status;
	} result_t;

	localparam int RES_W   = $bits(result_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic [2:0] words_for(input logic [7:0] bc, input logic [2:0] max_w);
		logic [2:0] n;
		n = 3'd1;
		if (bc > 8'd2 && n < max_w) n = n + 3'd1;
		if (bc > 8'd4 && n < max_w) n = n + 3'd1;
		if (bc > 8'd6 && n < max_w) n = n + 3'd1;
		return n;
	endfunction

endpackage

`default_nettype wire

### sv/modbus_rtu_response_receiver.sv
// Modbus RTU response receiver: counts, CRC-checks and decodes one response frame per gap.
// A gap is registered in stage 1, then its result in the output register; bytes yield none.
// One item per cycle unless a gap finds a result untaken; the bytewise CRC sets the cycle.
// Reset: asynchronous, clears count, CRC to 0xFFFF, header bytes, slave address to 1.
// Depends on mrr_pkg.
`default_nettype none

module modbus_rtu_response_receiver #(
	parameter int BUF_DEPTH = mrr_pkg::BUF_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [7:0]                  cfg_wr_data,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
	input  wire logic                        s_axis_tuser,  // [0] operation
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [2:0] status, [10:3] function_code, [13:11] word_count, [29:14] word_a,
	// [45:30] word_b, [61:46] word_c, [77:62] word_d, rest zero
	output logic [mrr_pkg::TDATA_W-1:0]      m_axis_tdata
);

	import mrr_pkg::*;

	localparam int CNT_W = $clog2(BUF_DEPTH + 1);

	logic             valid_s1;
	logic             op_s1;
	logic [7:0]       byte_s1;
	logic             s1_go;

	logic             valid_s2;
	result_t          res_s2;
	result_t          res;

	logic [7:0]       slave_address_q;
	logic [7:0]       hdr_q [HDR_LEN];
	logic [CNT_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [2:0]       wc;

	assign s1_go         = valid_s1 && (op_s1 == OP_BYTE || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDR_RST;
		end else if (cfg_wr_en) begin
			slave_address_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] <= 8'h00;
		end else if (s1_go) begin
			if (op_s1 == OP_GAP) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
			end else if (count_q != CNT_W'(BUF_DEPTH)) begin
				if (count_q < CNT_W'(HDR_LEN)) hdr_q[count_q[HDR_IDX_W-1:0]] <= byte_s1;
				crc_q   <= crc_byte(crc_q, byte_s1);
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		wc         = 3'd0;
		if (count_q < CNT_W'(MIN_FRAME)) begin
			res.status = ST_SHORT;
		end else begin
			res.function_code = hdr_q[1];
			if (hdr_q[0] != slave_address_q) begin
				res.status = ST_ADDR;
			end else if (crc_q != 16'h0000) begin
				res.status = ST_CRC;
			end else begin
				unique case (hdr_q[1])
					FC_READ_COILS:   wc = words_for(hdr_q[2], 3'd4);
					FC_READ_INPUTS:  wc = words_for(hdr_q[2], 3'd3);
					FC_READ_HOLDING: wc = words_for(hdr_q[2], 3'd2);
					FC_READ_INPUT_RG: begin
						if (hdr_q[2] == 8'd2) wc = 3'd1;
						else res.status = ST_LEN;
					end
					FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_MULTI: wc = 3'd0;
					default: res.status = ST_CODE;
				endcase
			end
		end
		res.word_count = wc;
		if (wc > 3'd0) res.word_a = {hdr_q[3], hdr_q[4]};
		if (wc > 3'd1) res.word_b = {hdr_q[5], hdr_q[6]};
		if (wc > 3'd2) res.word_c = {hdr_q[7], hdr_q[8]};
		if (wc > 3'd3) res.word_d = {hdr_q[9], hdr_q[10]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && op_s1 == OP_GAP) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1 == OP_GAP) res_s2 <= res;
	end

	a_reject_no_words: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status != ST_OK) |-> (res_s2.word_count == 3'd0))
		else $error("rejected frame carries words");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUF_DEPTH))
		else $error("byte count beyond buffer depth");

	a_gap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && op_s1 == OP_GAP) |=> (count_q == '0 && crc_q == CRC_INIT))
		else $error("gap did not clear count and crc");

	a_gap_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && op_s1 == OP_GAP) |=> valid_s2)
		else $error("gap produced no result");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && op_s1 == OP_GAP && valid_s2))
		else $error("input stalled without a pending result");

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for modbus_rtu_response_receiver: streams received bytes and frame gaps,
// predicts each gap's decode result from its own frame tracker and checks every result transfer.
// Depends on mrr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module tb;
	import mrr_pkg::*;

	localparam int RX_DEPTH = BUF_DEPTH_DEF;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} rx_item_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [7:0]           cfg_wr_data   = 8'h00;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = 8'h00;  // [7:0] rx_byte
	logic                 s_axis_tuser  = 1'b0;   // [0] operation
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [2:0] status, [10:3] function_code, [13:11] word_count, [29:14] word_a,
	// [45:30] word_b, [61:46] word_c, [77:62] word_d, rest zero
	logic [TDATA_W-1:0]   m_axis_tdata;

	rx_item_t    pending_rx[$];
	result_t     due_resp[$];
	logic [7:0]  frm[$];

	logic [7:0]  hdr_copy[HDR_LEN];
	int          rx_cnt;
	logic [15:0] rx_crc;
	logic [7:0]  rx_addr;

	logic [7:0]  cur_addr;
	bit          idle_on;
	logic        in_fire = 1'b0;
	int          src_gap;
	int          snk_gap;
	int          n_sent;
	int          n_taken;
	int          mismatches;

	modbus_rtu_response_receiver #(
		.BUF_DEPTH(RX_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] x;
		x = acc ^ {8'h00, d};
		repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		return x;
	endfunction

	function automatic logic [2:0] count_words(input logic [7:0] bc, input int cap);
		int n;
		n = 1 + int'(bc > 8'd2) + int'(bc > 8'd4) + int'(bc > 8'd6);
		if (n > cap) n = cap;
		return 3'(n);
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic track_rx(input logic op, input logic [7:0] d);
		result_t r;
		logic [2:0] nw;
		if (op == OP_BYTE) begin
			if (rx_cnt < RX_DEPTH) begin
				if (rx_cnt < HDR_LEN) hdr_copy[rx_cnt] = d;
				rx_crc = crc16_next(rx_crc, d);
				rx_cnt++;
			end
		end else begin
			r = '0;
			nw = 3'd0;
			if (rx_cnt < MIN_FRAME) begin
				r.status = ST_SHORT;
			end else begin
				r.function_code = hdr_copy[1];
				if (hdr_copy[0] != rx_addr) begin
					r.status = ST_ADDR;
				end else if (rx_crc != 16'h0000) begin
					r.status = ST_CRC;
				end else begin
					r.status = ST_OK;
					case (hdr_copy[1])
						FC_READ_COILS: nw = count_words(hdr_copy[2], 4);
						FC_READ_INPUTS: nw = count_words(hdr_copy[2], 3);
						FC_READ_HOLDING: nw = count_words(hdr_copy[2], 2);
						FC_READ_INPUT_RG: begin
							if (hdr_copy[2] == 8'd2) nw = 3'd1;
							else r.status = ST_LEN;
						end
						FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_MULTI: nw = 3'd0;
						default: r.status = ST_CODE;
					endcase
				end
			end
			r.word_count = nw;
			r.word_a = (nw > 3'd0) ? {hdr_copy[3], hdr_copy[4]} : 16'h0000;
			r.word_b = (nw > 3'd1) ? {hdr_copy[5], hdr_copy[6]} : 16'h0000;
			r.word_c = (nw > 3'd2) ? {hdr_copy[7], hdr_copy[8]} : 16'h0000;
			r.word_d = (nw > 3'd3) ? {hdr_copy[9], hdr_copy[10]} : 16'h0000;
			due_resp.push_back(r);
			rx_cnt = 0;
			rx_crc = CRC_INIT;
		end
	endtask

	// sample handshakes, check results, advance the frame tracker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (cfg_wr_en) rx_addr = cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[RES_W-1:0]);
				if ((m_axis_tdata >> RES_W) != 0)
					flag_mismatch("tdata padding", 64'(m_axis_tdata >> RES_W), 0);
				if (due_resp.size() == 0) begin
					flag_mismatch("result with none due", got.status, 0);
				end else begin
					want = due_resp.pop_front();
					if (got.status != want.status)
						flag_mismatch("status", got.status, want.status);
					if (got.function_code != want.function_code)
						flag_mismatch("function_code", got.function_code, want.function_code);
					if (got.word_count != want.word_count)
						flag_mismatch("word_count", got.word_count, want.word_count);
					if (got.word_a != want.word_a)
						flag_mismatch("word_a", got.word_a, want.word_a);
					if (got.word_b != want.word_b)
						flag_mismatch("word_b", got.word_b, want.word_b);
					if (got.word_c != want.word_c)
						flag_mismatch("word_c", got.word_c, want.word_c);
					if (got.word_d != want.word_d)
						flag_mismatch("word_d", got.word_d, want.word_d);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				track_rx(s_axis_tuser, s_axis_tdata);
				n_taken++;
			end
		end
	end

	// hold the current item until its transfer, then idle or present the next
	always @(negedge clk) begin
		rx_item_t it;
		if (!s_axis_tvalid || in_fire) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				src_gap = $urandom_range(1, 16) - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_rx.size() > 0) begin
				it = pending_rx.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= it.op;
				s_axis_tdata <= it.data;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (snk_gap > 0) begin
			snk_gap--;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			snk_gap = $urandom_range(1, 16) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic put_item(input logic op, input logic [7:0] d);
		pending_rx.push_back({op, d});
		n_sent++;
	endtask

	task automatic send_frame(input bit with_crc, input bit spoil, input int tail);
		logic [15:0] c;
		int p;
		c = CRC_INIT;
		foreach (frm[i]) c = crc16_next(c, frm[i]);
		if (with_crc) begin
			frm.push_back(c[7:0]);
			frm.push_back(c[15:8]);
		end
		if (spoil && frm.size() > 0) begin
			p = $urandom_range(0, frm.size() - 1);
			frm[p] = frm[p] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (frm[i]) put_item(OP_BYTE, frm[i]);
		repeat (tail) put_item(OP_BYTE, 8'($urandom_range(0, 255)));
		put_item(OP_GAP, 8'($urandom_range(0, 255)));
		frm.delete();
	endtask

	task automatic rand_frame();
		int sel;
		int n;
		logic [7:0] fc;
		logic [7:0] bc;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			n = (sel < 6) ? $urandom_range(0, 3) : $urandom_range(4, 16);
			repeat (n) frm.push_back(8'($urandom_range(0, 255)));
			send_frame(1'b0, 1'b0, 0);
		end else begin
			frm.push_back(sel < 18 ? cur_addr ^ 8'($urandom_range(1, 255)) : cur_addr);
			case ($urandom_range(0, 8))
				0: fc = FC_READ_COILS;
				1: fc = FC_READ_INPUTS;
				2: fc = FC_READ_HOLDING;
				3: fc = FC_READ_INPUT_RG;
				4: fc = FC_WRITE_COIL;
				5: fc = FC_WRITE_REG;
				6: fc = FC_WRITE_MULTI;
				default: fc = 8'($urandom_range(0, 255));
			endcase
			frm.push_back(fc);
			bc = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 8));
			if (fc == FC_READ_INPUT_RG && $urandom_range(0, 1) == 1) bc = 8'd2;
			n = ($urandom_range(0, 1) == 0 && bc <= 8'd8) ? int'(bc) : $urandom_range(0, 8);
			if ($urandom_range(0, 9) != 0) begin
				frm.push_back(bc);
				repeat (n) frm.push_back(8'($urandom_range(0, 255)));
			end
			send_frame(1'b1, sel >= 18 && sel < 28, 0);
		end
	endtask

	task automatic wait_drain();
		while (n_taken != n_sent || due_resp.size() != 0) @(posedge clk);
	endtask

	task automatic set_slave(input logic [7:0] addr);
		wait_drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= addr;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_addr = addr;
	endtask

	initial begin
		int budget;
		logic [7:0] plan[5];
		plan[0] = 8'h00;
		plan[1] = 8'hFF;
		plan[2] = 8'($urandom_range(0, 255));
		plan[3] = 8'($urandom_range(0, 255));
		plan[4] = SLAVE_ADDR_RST;

		for (int i = 0; i < HDR_LEN; i++) hdr_copy[i] = 8'h00;
		rx_cnt = 0;
		rx_crc = CRC_INIT;
		rx_addr = SLAVE_ADDR_RST;
		cur_addr = SLAVE_ADDR_RST;
		idle_on = 1'b1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty gap, short frame, wrong address, good single-word read, bad CRC
		send_frame(1'b0, 1'b0, 0);
		frm = '{8'h01, FC_READ_HOLDING, 8'h00};
		send_frame(1'b0, 1'b0, 0);
		frm = '{8'h02, FC_READ_HOLDING};
		send_frame(1'b1, 1'b0, 0);
		frm = '{8'h01, FC_READ_INPUT_RG, 8'h02, 8'h00, 8'hFF};
		send_frame(1'b1, 1'b0, 0);
		frm = '{8'h01, FC_WRITE_REG, 8'h00, 8'hFF};
		send_frame(1'b0, 1'b0, 0);

		budget = n_sent;
		for (int ph = 0; ph < 5; ph++) begin
			set_slave(plan[ph]);
			idle_on = (ph < 4) && (ph == 0 || $urandom_range(0, 2) != 0);
			if (ph == 0) begin
				// good frame that fills the buffer; trailing bytes drop
				frm.push_back(cur_addr);
				frm.push_back(FC_READ_COILS);
				frm.push_back(8'd8);
				while (frm.size() < RX_DEPTH - 2) frm.push_back(8'($urandom_range(0, 255)));
				send_frame(1'b1, 1'b0, $urandom_range(1, 24));
			end
			if (ph == 2) begin
				frm.push_back(cur_addr);
				repeat (RX_DEPTH - 6) frm.push_back(8'($urandom_range(0, 255)));
				send_frame(1'b0, 1'b0, $urandom_range(8, 40));
			end
			budget += (ph == 0 || ph == 2) ? 400 : 170;
			while (n_sent < budget) rand_frame();
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### modbus_rtu_response_receiver.f
sv/mrr_pkg.sv
sv/modbus_rtu_response_receiver.sv
sim/tb.sv
